// ===== rtl/core/at_response_ipd_deframer_macros.svh =====
// Assertion macros for the AT response deframer.
// Used by the top level; no other dependencies.
// Form: label, clock, active-low reset, property.
`ifndef AT_RESPONSE_IPD_DEFRAMER_MACROS_SVH
`define AT_RESPONSE_IPD_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define ATIPD_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error("atipd assertion failed");
`define ATIPD_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("atipd assertion failed");
`else
`define ATIPD_ASSERT(lbl, clk_s, rst_s, prop)
`define ATIPD_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

// ===== rtl/core/atipd_pkg.sv =====
// Types and constants for the AT response "+IPD" deframer.
// No dependencies.
package atipd_pkg;

  localparam int unsigned TailBytes = 7;
  localparam logic [7:0] MinHeader  = 8'd7;
  localparam logic [7:0] LengthStrt = 8'd5;
  localparam logic [7:0] ColonChar  = 8'h3a;
  localparam logic [7:0] ZeroChar   = 8'h30;
  localparam logic [7:0] PromptChar = 8'h3e;

  localparam logic [31:0] OkText    = 32'h4f4b_0d0a;
  localparam logic [55:0] ErrorText = 56'h45_5252_4f52_0d0a;
  localparam logic [47:0] FailText  = 48'h4641_494c_0d0a;

  localparam logic [0:0] OpByte  = 1'b0;
  localparam logic [0:0] OpClear = 1'b1;

  typedef struct packed {
    logic [7:0]             byte_count;
    logic                   prefix_match;
    logic [7:0]             length_acc;
    logic                   colon_seen;
    logic [7:0]             payload_count;
    logic [8*TailBytes-1:0] tail_bytes;
    logic [2:0]             tail_length;
  } state_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] declared_length;
    logic       frame_complete;
    logic       ends_with_ok;
    logic       ends_with_error;
    logic       ends_with_fail;
    logic       ends_with_prompt;
    logic       overflow;
  } result_t;

  localparam state_t StateReset = '{
    byte_count:    8'd0,
    prefix_match:  1'b1,
    length_acc:    8'd0,
    colon_seen:    1'b0,
    payload_count: 8'd0,
    tail_bytes:    '0,
    tail_length:   3'd0
  };

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h2b;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h2c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/atipd_step.sv =====
// Per-transaction next-state and result logic of the "+IPD" deframer.
// Depends on atipd_pkg.
module atipd_step #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic               op,
  input  logic [7:0]         rx_byte,
  input  atipd_pkg::state_t  cur,
  output atipd_pkg::state_t  nxt,
  output atipd_pkg::result_t res
);
  import atipd_pkg::*;

  localparam logic [7:0] MaxBytes = 8'(MAX_FRAME_BYTES);

  state_t     s;
  logic       pvalid;
  logic       room;
  logic [7:0] acc_x10;

  assign room    = (cur.byte_count < MaxBytes);
  assign acc_x10 = {cur.length_acc[4:0], 3'b000} + {cur.length_acc[6:0], 1'b0};

  always_comb begin
    s      = cur;
    pvalid = 1'b0;
    if (op == OpClear) begin
      s = StateReset;
    end else if (room) begin
      if (cur.byte_count < LengthStrt) begin
        if (rx_byte != prefix_char(cur.byte_count[2:0])) begin
          s.prefix_match = 1'b0;
        end
      end else if (cur.colon_seen) begin
        s.payload_count = cur.payload_count + 8'd1;
        pvalid          = cur.prefix_match;
      end else if (rx_byte == ColonChar) begin
        s.colon_seen = 1'b1;
      end else begin
        s.length_acc = acc_x10 + rx_byte - ZeroChar;
      end
      s.byte_count = cur.byte_count + 8'd1;
      s.tail_bytes = {cur.tail_bytes[8*TailBytes-9:0], rx_byte};
      if (cur.tail_length < 3'(TailBytes)) begin
        s.tail_length = cur.tail_length + 3'd1;
      end
    end
  end

  assign nxt = s;

  always_comb begin
    res                  = '0;
    res.payload_valid    = pvalid;
    res.payload_byte     = pvalid ? rx_byte : 8'd0;
    res.declared_length  = s.length_acc;
    res.frame_complete   = (op == OpByte) && room && (s.byte_count > MinHeader) &&
                           s.prefix_match && s.colon_seen &&
                           (s.payload_count == s.length_acc);
    res.ends_with_ok     = (s.tail_length >= 3'd4) && (s.tail_bytes[31:0] == OkText);
    res.ends_with_error  = (s.tail_length >= 3'd7) && (s.tail_bytes[55:0] == ErrorText);
    res.ends_with_fail   = (s.tail_length >= 3'd6) && (s.tail_bytes[47:0] == FailText);
    res.ends_with_prompt = (s.tail_length >= 3'd1) && (s.tail_bytes[7:0] == PromptChar);
    res.overflow         = (s.byte_count >= MaxBytes);
  end

endmodule

// ===== rtl/core/at_response_ipd_deframer.sv =====
// Top level of the AT response "+IPD" deframer: stream in, stream out.
// Depends on atipd_pkg, atipd_step and at_response_ipd_deframer_macros.svh.
//
//  channel | dir | tdata                    | tuser
//  in_     | in  | rx_byte                  | operation
//  out_    | out | result fields (see port) | payload_valid
//
// State and result register update on acceptance.
// A new transaction is taken every cycle while the result register is empty
// or being drained; out_tready low holds the result and stalls the input.
// Synchronous active-low reset restores the empty receive state.
`include "at_response_ipd_deframer_macros.svh"

module at_response_ipd_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [15:8] declared_length,
                                  // [16] frame_complete, [17] ends_with_ok,
                                  // [18] ends_with_error, [19] ends_with_fail,
                                  // [20] ends_with_prompt, [21] overflow, [23:22] 0
  output logic        out_tuser   // [0] payload_valid
);
  import atipd_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_acc;

  atipd_step #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_step (
    .op      (in_tuser),
    .rx_byte (in_tdata),
    .cur     (state_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StateReset;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.payload_valid;
  assign out_tdata  = {2'b00, res_r.overflow, res_r.ends_with_prompt, res_r.ends_with_fail,
                       res_r.ends_with_error, res_r.ends_with_ok, res_r.frame_complete,
                       res_r.declared_length, res_r.payload_byte};

  `ATIPD_ASSERT(a_count_bound, clk, rst_n, state_r.byte_count <= 8'(MAX_FRAME_BYTES))
  `ATIPD_ASSERT(a_pvalid_state, clk, rst_n, (out_valid_r && res_r.payload_valid) |-> (state_r.prefix_match && state_r.colon_seen))
  `ATIPD_ASSERT(a_done_header, clk, rst_n, (out_valid_r && res_r.frame_complete) |-> (state_r.byte_count > MinHeader))
  `ATIPD_ASSERT(a_clear, clk, rst_n, (in_acc && (in_tuser == OpClear)) |=> (state_r == StateReset))
  `ATIPD_ASSERT_ALWAYS(a_ready_empty, clk, !out_valid_r |-> in_tready)

endmodule
